### rtl/tick_scheduler_with_gated_counters_defines.svh
// Assertion macros shared by the tick scheduler RTL.
// Depends on nothing; modules that assert include it by bare file name.
`ifndef TICK_SCHEDULER_WITH_GATED_COUNTERS_DEFINES_SVH
`define TICK_SCHEDULER_WITH_GATED_COUNTERS_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TSGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Check a property on every clock edge, reset included.
`define TSGC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define TSGC_ASSERT(lbl, prop, msg)
`define TSGC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/tsgc_pkg.sv
// Shared types, codes and constants of the tick scheduler.
// Depends on nothing; used by every RTL module of the block.
`default_nettype none

package tsgc_pkg;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    // Flag slots reachable through the 4-bit request index
    localparam int MAX_FLAGS = 16;

    // Input opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SET_FLAG  = 3'd1;
    localparam logic [2:0] OP_READ      = 3'd2;
    localparam logic [2:0] OP_RESET     = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd4;

    // Counter selectors
    localparam logic [2:0] SEL_CPU       = 3'd0;
    localparam logic [2:0] SEL_INTSET    = 3'd1;
    localparam logic [2:0] SEL_INTHOLD   = 3'd2;
    localparam logic [2:0] SEL_HANDSHAKE = 3'd3;
    localparam logic [2:0] SEL_DERATE    = 3'd4;
    localparam logic [2:0] SEL_BATTERY   = 3'd5;
    localparam logic [2:0] SEL_WATCHDOG  = 3'd6;
    localparam logic [2:0] SEL_NONE      = 3'd7;

    // Result event kinds
    localparam logic [3:0] EV_REQUEST   = 4'd0;
    localparam logic [3:0] EV_DIMMING   = 4'd1;
    localparam logic [3:0] EV_BATFLOW   = 4'd2;
    localparam logic [3:0] EV_BACKLIGHT = 4'd3;
    localparam logic [3:0] EV_POWER     = 4'd4;
    localparam logic [3:0] EV_DEBUG     = 4'd5;
    localparam logic [3:0] EV_MONITOR   = 4'd6;
    localparam logic [3:0] EV_WATCHDOG  = 4'd7;
    localparam logic [3:0] EV_READ      = 4'd8;

    // Pending-event slots, in emission order
    localparam int SLOT_DIMMING  = 0;
    localparam int SLOT_BATFLOW  = 1;
    localparam int SLOT_BACKLITE = 2;
    localparam int SLOT_POWER    = 3;
    localparam int SLOT_WATCHDOG = 4;
    localparam int SLOT_DEBUG    = 5;
    localparam int SLOT_MONITOR  = 6;
    localparam int SLOT_READ     = 7;
    localparam int SLOT_COUNT    = 8;
    localparam int SLOT_W        = $clog2(SLOT_COUNT);

    // Gate enable bits
    localparam int GATE_RUN     = 0;
    localparam int GATE_DERATE  = 1;
    localparam int GATE_BATTERY = 2;
    localparam int GATE_INTSET  = 3;
    localparam int GATE_INTHOLD = 4;
    localparam int GATE_W       = 5;

    // Configuration register indexes
    localparam logic CFG_GATE_ENABLES     = 1'b0;
    localparam logic CFG_WATCHDOG_TRIGGER = 1'b1;
    localparam int   CFG_DATA_W           = 32;
    localparam logic [CFG_DATA_W-1:0] WATCHDOG_RESET = 32'd1000;

    // Periods of the fixed-rate events, in ticks
    localparam int PERIOD_DIMMING  = 6;
    localparam int PERIOD_BATFLOW  = 10;
    localparam int PERIOD_BACKLITE = 15;
    localparam int PERIOD_POWER    = 100;

    // Read value of selectors without a counter
    localparam logic [7:0] READ_NONE = 8'hFF;

    // Commands passed from front to back
    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_SET,
        CMD_READ,
        CMD_RESET,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] index;
        logic [2:0] sel;
    } cmd_t;

    // Map a pending-event slot to its result kind
    function automatic logic [3:0] slot_kind(input logic [SLOT_W-1:0] slot);
        logic [3:0] kind;
        unique case (slot)
            3'(SLOT_DIMMING):  kind = EV_DIMMING;
            3'(SLOT_BATFLOW):  kind = EV_BATFLOW;
            3'(SLOT_BACKLITE): kind = EV_BACKLIGHT;
            3'(SLOT_POWER):    kind = EV_POWER;
            3'(SLOT_WATCHDOG): kind = EV_WATCHDOG;
            3'(SLOT_DEBUG):    kind = EV_DEBUG;
            3'(SLOT_MONITOR):  kind = EV_MONITOR;
            default:           kind = EV_READ;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

### rtl/tsgc_front.sv
// Front end: accepts input requests and classifies them into commands.
// Depends on tsgc_pkg; feeds tsgc_queue.
`default_nettype none

module tsgc_front #(
    parameter int FLAGS = 16
) (
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [2:0]      opcode,
    input  wire logic [3:0]      request_index,
    input  wire logic [2:0]      counter_select,
    input  wire logic            q_full,
    output logic                 push,
    output tsgc_pkg::cmd_t       cmd
);

    logic keep;

    // Take a request whenever the queue has room
    assign in_ready = !q_full;

    // Decode the opcode; drop requests that change nothing and give no result
    always_comb
    begin
        keep      = 1'b1;
        cmd.index = request_index;
        cmd.sel   = counter_select;
        cmd.kind  = tsgc_pkg::CMD_TICK;
        unique case (opcode)
            tsgc_pkg::OP_TICK:
            begin
                cmd.kind = tsgc_pkg::CMD_TICK;
            end
            tsgc_pkg::OP_SET_FLAG:
            begin
                cmd.kind = tsgc_pkg::CMD_SET;
                keep     = ({1'b0, request_index} < 5'(FLAGS));
            end
            tsgc_pkg::OP_READ:
            begin
                cmd.kind = tsgc_pkg::CMD_READ;
            end
            tsgc_pkg::OP_RESET:
            begin
                cmd.kind = tsgc_pkg::CMD_RESET;
                keep     = (counter_select != tsgc_pkg::SEL_HANDSHAKE) &&
                           (counter_select != tsgc_pkg::SEL_NONE);
            end
            tsgc_pkg::OP_CLEAR_ALL:
            begin
                cmd.kind = tsgc_pkg::CMD_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = in_valid && in_ready && keep;

endmodule

`default_nettype wire

### rtl/tsgc_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on tsgc_pkg and the assertion macro header.
`default_nettype none

`include "tick_scheduler_with_gated_counters_defines.svh"

module tsgc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  tsgc_pkg::cmd_t      cmd_in,
    output logic                full,
    input  wire logic           pop,
    output tsgc_pkg::cmd_t      cmd_out,
    output logic                empty
);

    localparam int DEPTH = tsgc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsgc_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    `TSGC_ASSERT_ALWAYS(a_no_push_full, !(push && full), "command pushed into full queue")
    `TSGC_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "command popped from empty queue")

endmodule

`default_nettype wire

### rtl/tsgc_back.sv
// Back end: holds counters, flags and configuration, executes commands and
// emits result events one per cycle, while the receiver is ready, through an output register.
// Depends on tsgc_pkg and the assertion macro header.
`default_nettype none

`include "tick_scheduler_with_gated_counters_defines.svh"

module tsgc_back #(
    parameter int FLAGS            = 16,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [tsgc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              q_empty,
    input  tsgc_pkg::cmd_t                         cmd,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [3:0]                             event_kind,
    output logic [3:0]                             request_number,
    output logic [7:0]                             read_value,
    output logic                                   last
);

    localparam int P6_W   = $clog2(tsgc_pkg::PERIOD_DIMMING);
    localparam int P10_W  = $clog2(tsgc_pkg::PERIOD_BATFLOW);
    localparam int P15_W  = $clog2(tsgc_pkg::PERIOD_BACKLITE);
    localparam int P100_W = $clog2(tsgc_pkg::PERIOD_POWER);
    localparam int SEC_W  = $clog2(TICKS_PER_SECOND);
    localparam int SW     = tsgc_pkg::SLOT_W;
    localparam int SC     = tsgc_pkg::SLOT_COUNT;

    // Configuration
    logic [tsgc_pkg::GATE_W-1:0]     gate_reg;
    logic [tsgc_pkg::CFG_DATA_W-1:0] trigger_reg;

    // Phase counters, one per period
    logic [P6_W-1:0]   ph6_reg,   ph6_next,   ph6_inc;
    logic [P10_W-1:0]  ph10_reg,  ph10_next,  ph10_inc;
    logic [P15_W-1:0]  ph15_reg,  ph15_next,  ph15_inc;
    logic [P100_W-1:0] ph100_reg, ph100_next, ph100_inc;
    logic [SEC_W-1:0]  phsec_reg, phsec_next, phsec_inc;

    // Counters
    logic [31:0] cpu_reg,     cpu_next;
    logic [31:0] intset_reg,  intset_next;
    logic [31:0] inthold_reg, inthold_next;
    logic [31:0] derate_reg,  derate_next;
    logic [31:0] battery_reg, battery_next;
    logic [31:0] wdog_reg,    wdog_next, wdog_inc;

    // Request flags and pending events
    logic [FLAGS-1:0] flags_reg,     flags_next;
    logic [FLAGS-1:0] pend_flags_reg, pend_flags_next, pend_flags_rest;
    logic [SC-1:0]    pend_ev_reg,   pend_ev_next,   pend_ev_rest;
    logic [7:0]       rd_value_reg,  rd_value_next,  rd_sel_value;
    logic             pend_any;
    logic [3:0]       first_flag;
    logic [SW-1:0]    first_slot;
    logic [SC-1:0]    tick_ev;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       kind_reg,  kind_next;
    logic [3:0]       num_reg,   num_next;
    logic [7:0]       value_reg, value_next;
    logic             last_reg,  last_next;
    logic             emit_fire;

    assign pend_any  = (pend_flags_reg != '0) || (pend_ev_reg != '0);
    assign pop       = !pend_any && !q_empty;
    assign emit_fire = pend_any && (!out_valid_reg || out_ready);

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign request_number = num_reg;
    assign read_value     = value_reg;
    assign last           = last_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg    <= '0;
            trigger_reg <= tsgc_pkg::WATCHDOG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tsgc_pkg::CFG_GATE_ENABLES)
            begin
                gate_reg <= cfg_data[tsgc_pkg::GATE_W-1:0];
            end
            else
            begin
                trigger_reg <= cfg_data;
            end
        end
    end

    // Advance the phase counters and watchdog count by one tick
    always_comb
    begin
        ph6_inc   = (ph6_reg == P6_W'(tsgc_pkg::PERIOD_DIMMING - 1)) ? '0 : ph6_reg + 1'b1;
        ph10_inc  = (ph10_reg == P10_W'(tsgc_pkg::PERIOD_BATFLOW - 1)) ? '0 : ph10_reg + 1'b1;
        ph15_inc  = (ph15_reg == P15_W'(tsgc_pkg::PERIOD_BACKLITE - 1)) ? '0 : ph15_reg + 1'b1;
        ph100_inc = (ph100_reg == P100_W'(tsgc_pkg::PERIOD_POWER - 1)) ? '0 : ph100_reg + 1'b1;
        phsec_inc = (phsec_reg == SEC_W'(TICKS_PER_SECOND - 1)) ? '0 : phsec_reg + 1'b1;
        wdog_inc  = wdog_reg + 32'd1;
    end

    // Collect the fixed events of a tick
    always_comb
    begin
        tick_ev = '0;
        tick_ev[tsgc_pkg::SLOT_DIMMING]  = gate_reg[tsgc_pkg::GATE_RUN] && (ph6_inc == '0);
        tick_ev[tsgc_pkg::SLOT_BATFLOW]  = gate_reg[tsgc_pkg::GATE_RUN] && (ph10_inc == '0);
        tick_ev[tsgc_pkg::SLOT_BACKLITE] = gate_reg[tsgc_pkg::GATE_RUN] && (ph15_inc == '0);
        tick_ev[tsgc_pkg::SLOT_POWER]    = gate_reg[tsgc_pkg::GATE_RUN] && (ph100_inc == '0);
        tick_ev[tsgc_pkg::SLOT_WATCHDOG] = (wdog_inc == trigger_reg);
        tick_ev[tsgc_pkg::SLOT_DEBUG]    = (phsec_inc == '0);
        tick_ev[tsgc_pkg::SLOT_MONITOR]  = (phsec_inc == '0);
    end

    // Select the low byte of a counter for a read
    always_comb
    begin
        unique case (cmd.sel)
            tsgc_pkg::SEL_CPU:      rd_sel_value = cpu_reg[7:0];
            tsgc_pkg::SEL_INTSET:   rd_sel_value = intset_reg[7:0];
            tsgc_pkg::SEL_INTHOLD:  rd_sel_value = inthold_reg[7:0];
            tsgc_pkg::SEL_DERATE:   rd_sel_value = derate_reg[7:0];
            tsgc_pkg::SEL_BATTERY:  rd_sel_value = battery_reg[7:0];
            tsgc_pkg::SEL_WATCHDOG: rd_sel_value = wdog_reg[7:0];
            default:                rd_sel_value = tsgc_pkg::READ_NONE;
        endcase
    end

    // Find the lowest pending flag and the first pending event slot
    always_comb
    begin
        first_flag = '0;
        for (int i = FLAGS - 1; i >= 0; i--)
        begin
            if (pend_flags_reg[i])
            begin
                first_flag = 4'(i);
            end
        end
        first_slot = '0;
        for (int j = SC - 1; j >= 0; j--)
        begin
            if (pend_ev_reg[j])
            begin
                first_slot = SW'(j);
            end
        end
        pend_flags_rest = pend_flags_reg & (pend_flags_reg - FLAGS'(1));
        pend_ev_rest    = pend_ev_reg & (pend_ev_reg - SC'(1));
    end

    // Execute a popped command or emit the next pending event
    always_comb
    begin
        ph6_next        = ph6_reg;
        ph10_next       = ph10_reg;
        ph15_next       = ph15_reg;
        ph100_next      = ph100_reg;
        phsec_next      = phsec_reg;
        cpu_next        = cpu_reg;
        intset_next     = intset_reg;
        inthold_next    = inthold_reg;
        derate_next     = derate_reg;
        battery_next    = battery_reg;
        wdog_next       = wdog_reg;
        flags_next      = flags_reg;
        pend_flags_next = pend_flags_reg;
        pend_ev_next    = pend_ev_reg;
        rd_value_next   = rd_value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        num_next        = num_reg;
        value_next      = value_reg;
        last_next       = last_reg;

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            if (pend_flags_reg != '0)
            begin
                kind_next       = tsgc_pkg::EV_REQUEST;
                num_next        = first_flag;
                value_next      = '0;
                pend_flags_next = pend_flags_rest;
            end
            else
            begin
                kind_next    = tsgc_pkg::slot_kind(first_slot);
                num_next     = '0;
                value_next   = (first_slot == SW'(tsgc_pkg::SLOT_READ)) ? rd_value_reg : '0;
                pend_ev_next = pend_ev_rest;
            end
            last_next = (pend_flags_next == '0) && (pend_ev_next == '0);
        end
        else if (pop)
        begin
            unique case (cmd.kind)
                tsgc_pkg::CMD_TICK:
                begin
                    ph6_next   = ph6_inc;
                    ph10_next  = ph10_inc;
                    ph15_next  = ph15_inc;
                    ph100_next = ph100_inc;
                    phsec_next = phsec_inc;
                    cpu_next   = cpu_reg + 32'd1;
                    wdog_next  = wdog_inc;
                    if (gate_reg[tsgc_pkg::GATE_INTSET])
                    begin
                        intset_next = intset_reg + 32'd1;
                    end
                    if (gate_reg[tsgc_pkg::GATE_INTHOLD])
                    begin
                        inthold_next = inthold_reg + 32'd1;
                    end
                    if (phsec_inc == '0)
                    begin
                        if (gate_reg[tsgc_pkg::GATE_DERATE])
                        begin
                            derate_next = derate_reg + 32'd1;
                        end
                        if (gate_reg[tsgc_pkg::GATE_BATTERY])
                        begin
                            battery_next = battery_reg + 32'd1;
                        end
                    end
                    if (gate_reg[tsgc_pkg::GATE_RUN])
                    begin
                        pend_flags_next = flags_reg;
                        flags_next      = '0;
                    end
                    pend_ev_next = tick_ev;
                end
                tsgc_pkg::CMD_SET:
                begin
                    flags_next[cmd.index[$clog2(FLAGS > 1 ? FLAGS : 2)-1:0]] = 1'b1;
                end
                tsgc_pkg::CMD_READ:
                begin
                    rd_value_next                      = rd_sel_value;
                    pend_ev_next[tsgc_pkg::SLOT_READ]  = 1'b1;
                end
                tsgc_pkg::CMD_RESET:
                begin
                    unique case (cmd.sel)
                        tsgc_pkg::SEL_CPU:      cpu_next     = '0;
                        tsgc_pkg::SEL_INTSET:   intset_next  = '0;
                        tsgc_pkg::SEL_INTHOLD:  inthold_next = '0;
                        tsgc_pkg::SEL_DERATE:   derate_next  = '0;
                        tsgc_pkg::SEL_BATTERY:  battery_next = '0;
                        tsgc_pkg::SEL_WATCHDOG: wdog_next    = '0;
                        default:                cpu_next     = cpu_reg;
                    endcase
                end
                tsgc_pkg::CMD_CLEAR:
                begin
                    flags_next = '0;
                end
                default:
                begin
                    flags_next = flags_reg;
                end
            endcase
        end
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph6_reg        <= '0;
            ph10_reg       <= '0;
            ph15_reg       <= '0;
            ph100_reg      <= '0;
            phsec_reg      <= '0;
            cpu_reg        <= '0;
            intset_reg     <= '0;
            inthold_reg    <= '0;
            derate_reg     <= '0;
            battery_reg    <= '0;
            wdog_reg       <= '0;
            flags_reg      <= '0;
            pend_flags_reg <= '0;
            pend_ev_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ph6_reg        <= ph6_next;
            ph10_reg       <= ph10_next;
            ph15_reg       <= ph15_next;
            ph100_reg      <= ph100_next;
            phsec_reg      <= phsec_next;
            cpu_reg        <= cpu_next;
            intset_reg     <= intset_next;
            inthold_reg    <= inthold_next;
            derate_reg     <= derate_next;
            battery_reg    <= battery_next;
            wdog_reg       <= wdog_next;
            flags_reg      <= flags_next;
            pend_flags_reg <= pend_flags_next;
            pend_ev_reg    <= pend_ev_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_value_reg <= rd_value_next;
        kind_reg     <= kind_next;
        num_reg      <= num_next;
        value_reg    <= value_next;
        last_reg     <= last_next;
    end

    `TSGC_ASSERT(a_pop_when_idle, pop |-> !pend_any && !emit_fire, "command taken while busy")
    `TSGC_ASSERT(a_last_drains, (emit_fire && last_next) |=> !pend_any, "events left after last")
    `TSGC_ASSERT(a_more_pending, (emit_fire && !last_next) |=> pend_any, "last missing on final event")
    `TSGC_ASSERT_ALWAYS(a_read_alone, !pend_ev_reg[tsgc_pkg::SLOT_READ] || ((pend_flags_reg == '0) && (pend_ev_reg[tsgc_pkg::SLOT_READ-1:0] == '0)), "read mixed with tick events")

endmodule

`default_nettype wire

### rtl/tick_scheduler_with_gated_counters.sv
// Top level of the tick scheduler: front end, command queue and back end.
// Depends on tsgc_pkg, tsgc_front, tsgc_queue and tsgc_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a 1 ms tick, a
//   flag set, a counter read, a counter reset or a clear of all flags.
//   Output channel (out_valid/out_ready) carries result events; last marks
//   the final event caused by one request. Requests with no events give
//   no result.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   A request enters a two-entry queue at acceptance; the back end pops it
//   when no events are pending, and its first event then goes out through
//   the output register. The back end handles one request at a time: it
//   executes the request, emits its events one by one while the receiver
//   accepts them, and pops the next request once none are pending.
// Reset clears counters, phase, flags, the queue and the output register;
//   gate_enables resets to 0 and watchdog_trigger to 1000.
// A stalled receiver holds the current event; the queue keeps accepting
//   requests until it fills, then in_ready drops.
`default_nettype none

module tick_scheduler_with_gated_counters #(
    parameter int REQUEST_SLOTS    = 16,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [2:0]                        opcode,
    input  wire logic [3:0]                        request_index,
    input  wire logic [2:0]                        counter_select,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [3:0]                             event_kind,
    output logic [3:0]                             request_number,
    output logic [7:0]                             read_value,
    output logic                                   last,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [tsgc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Only flags reachable by the request index get storage
    localparam int FLAGS = (REQUEST_SLOTS < tsgc_pkg::MAX_FLAGS) ?
                           REQUEST_SLOTS : tsgc_pkg::MAX_FLAGS;

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    tsgc_pkg::cmd_t cmd_in;
    tsgc_pkg::cmd_t cmd_out;

    tsgc_front #(
        .FLAGS          (FLAGS)
    ) u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .request_index  (request_index),
        .counter_select (counter_select),
        .q_full         (q_full),
        .push           (push),
        .cmd            (cmd_in)
    );

    tsgc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_in),
        .full    (q_full),
        .pop     (pop),
        .cmd_out (cmd_out),
        .empty   (q_empty)
    );

    tsgc_back #(
        .FLAGS            (FLAGS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_empty        (q_empty),
        .cmd            (cmd_out),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .request_number (request_number),
        .read_value     (read_value),
        .last           (last)
    );

endmodule

`default_nettype wire

### test/tick_scheduler_with_gated_counters_tb.sv
// Self-checking testbench for the tick scheduler: a directed table, mixed
// random requests and a long tick run past the phase wrap, all predicted here.
// Depends on tsgc_pkg and tick_scheduler_with_gated_counters.
module tick_scheduler_with_gated_counters_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsgc_pkg::*;

    localparam int TICKS_PER_SECOND = 1000;
    // Phase period: lcm of 300 and the ticks per second
    localparam int PHASE_WRAP       = 3000;
    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 11;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int TIMEOUT_NS       = 10_000_000;

    // Opcodes the block ignores
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] number;
        logic [7:0] value;
        logic       last;
    } sched_event_t;

    typedef enum logic {
        ROW_REQ,
        ROW_WRITE
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic                   reg_sel;
        logic [CFG_DATA_W-1:0]  data;
        logic [2:0]             op;
        logic [3:0]             idx;
        logic [2:0]             sel;
        logic                   typed;
        logic [7:0]             typed_val;
    } step_row_t;

    // Directed steps; typed rows carry their read value, the rest are predicted
    localparam int DIRECTED_ROWS = 30;
    localparam step_row_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        '{ROW_REQ,   1'b0, 32'd0, OP_READ,      4'd0,  SEL_CPU,       1'b1, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_READ,      4'd5,  SEL_HANDSHAKE, 1'b1, READ_NONE},
        '{ROW_REQ,   1'b0, 32'd0, OP_READ,      4'd15, SEL_NONE,      1'b1, READ_NONE},
        '{ROW_REQ,   1'b0, 32'd0, OP_READ,      4'd0,  SEL_BATTERY,   1'b1, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_TICK,      4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_SET_FLAG,  4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_SET_FLAG,  4'd15, SEL_NONE,      1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_TICK,      4'd15, SEL_NONE,      1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_SPARE5,    4'd15, SEL_NONE,      1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_SPARE6,    4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_SPARE7,    4'd15, SEL_NONE,      1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_RESET,     4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_RESET,     4'd0,  SEL_HANDSHAKE, 1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_RESET,     4'd0,  SEL_NONE,      1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_READ,      4'd0,  SEL_CPU,       1'b1, 8'd0},
        '{ROW_WRITE, CFG_GATE_ENABLES,     32'd31, OP_TICK, 4'd0, SEL_CPU, 1'b0, 8'd0},
        '{ROW_WRITE, CFG_WATCHDOG_TRIGGER, 32'd5,  OP_TICK, 4'd0, SEL_CPU, 1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_TICK,      4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_SET_FLAG,  4'd10, SEL_DERATE,    1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_TICK,      4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_TICK,      4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_TICK,      4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_SET_FLAG,  4'd7,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_CLEAR_ALL, 4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_TICK,      4'd0,  SEL_CPU,       1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_READ,      4'd0,  SEL_INTSET,    1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_RESET,     4'd0,  SEL_WATCHDOG,  1'b0, 8'd0},
        '{ROW_REQ,   1'b0, 32'd0, OP_READ,      4'd0,  SEL_WATCHDOG,  1'b1, 8'd0},
        '{ROW_WRITE, CFG_GATE_ENABLES,     32'd0,          OP_TICK, 4'd0, SEL_CPU, 1'b0, 8'd0},
        '{ROW_WRITE, CFG_WATCHDOG_TRIGGER, 32'hFFFF_FFFF,  OP_TICK, 4'd0, SEL_CPU, 1'b0, 8'd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [2:0]             opcode;
    logic [3:0]             request_index;
    logic [2:0]             counter_select;
    logic                   out_valid;
    logic                   out_ready;
    logic [3:0]             event_kind;
    logic [3:0]             request_number;
    logic [7:0]             read_value;
    logic                   last;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted scheduler state and configuration
    int                     sched_phase;
    logic [31:0]            cpu_ms;
    logic [31:0]            intset_ms;
    logic [31:0]            inthold_ms;
    logic [31:0]            derate_s;
    logic [31:0]            battery_s;
    logic [31:0]            wdog_ms;
    logic [MAX_FLAGS-1:0]   flag_bits;
    logic [GATE_W-1:0]      gate_cfg;
    logic [31:0]            wdog_trig;

    sched_event_t           step_events[$];
    sched_event_t           pending_events[$];
    int                     fail_count;
    bit                     quiet;
    bit                     long_hold_req;

    tick_scheduler_with_gated_counters #(
        .REQUEST_SLOTS    (MAX_FLAGS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .request_index  (request_index),
        .counter_select (counter_select),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .request_number (request_number),
        .read_value     (read_value),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Append one event of the current request
    function automatic void note_event(input logic [3:0] kind, input logic [3:0] number,
                                       input logic [7:0] value);
        step_events.push_back('{kind, number, value, 1'b0});
    endfunction

    // Work out the events of one request and advance the predicted state
    function automatic void model_request(input logic [2:0] op, input logic [3:0] idx,
                                          input logic [2:0] sel);
        logic [7:0] low_byte;
        step_events.delete();
        case (op)
            OP_TICK:
            begin
                sched_phase = (sched_phase + 1) % PHASE_WRAP;
                cpu_ms = cpu_ms + 1;
                if (gate_cfg[GATE_INTSET])
                    intset_ms = intset_ms + 1;
                if (gate_cfg[GATE_INTHOLD])
                    inthold_ms = inthold_ms + 1;
                if (gate_cfg[GATE_RUN])
                begin
                    // Service pending flags in index order, then the periodic events
                    for (int f = 0; f < MAX_FLAGS; f++)
                    begin
                        if (flag_bits[f])
                            note_event(EV_REQUEST, 4'(f), 8'd0);
                    end
                    flag_bits = '0;
                    if (sched_phase % PERIOD_DIMMING == 0)
                        note_event(EV_DIMMING, 4'd0, 8'd0);
                    if (sched_phase % PERIOD_BATFLOW == 0)
                        note_event(EV_BATFLOW, 4'd0, 8'd0);
                    if (sched_phase % PERIOD_BACKLITE == 0)
                        note_event(EV_BACKLIGHT, 4'd0, 8'd0);
                    if (sched_phase % PERIOD_POWER == 0)
                        note_event(EV_POWER, 4'd0, 8'd0);
                end
                wdog_ms = wdog_ms + 1;
                if (wdog_ms == wdog_trig)
                    note_event(EV_WATCHDOG, 4'd0, 8'd0);
                if (sched_phase % TICKS_PER_SECOND == 0)
                begin
                    note_event(EV_DEBUG, 4'd0, 8'd0);
                    note_event(EV_MONITOR, 4'd0, 8'd0);
                    if (gate_cfg[GATE_DERATE])
                        derate_s = derate_s + 1;
                    if (gate_cfg[GATE_BATTERY])
                        battery_s = battery_s + 1;
                end
            end
            OP_SET_FLAG:
                flag_bits[idx] = 1'b1;
            OP_READ:
            begin
                case (sel)
                    SEL_CPU:      low_byte = cpu_ms[7:0];
                    SEL_INTSET:   low_byte = intset_ms[7:0];
                    SEL_INTHOLD:  low_byte = inthold_ms[7:0];
                    SEL_DERATE:   low_byte = derate_s[7:0];
                    SEL_BATTERY:  low_byte = battery_s[7:0];
                    SEL_WATCHDOG: low_byte = wdog_ms[7:0];
                    default:      low_byte = READ_NONE;
                endcase
                note_event(EV_READ, 4'd0, low_byte);
            end
            OP_RESET:
            begin
                case (sel)
                    SEL_CPU:      cpu_ms = '0;
                    SEL_INTSET:   intset_ms = '0;
                    SEL_INTHOLD:  inthold_ms = '0;
                    SEL_DERATE:   derate_s = '0;
                    SEL_BATTERY:  battery_s = '0;
                    SEL_WATCHDOG: wdog_ms = '0;
                    default:      ;
                endcase
            end
            OP_CLEAR_ALL:
                flag_bits = '0;
            default:
                ;
        endcase
        if (step_events.size() != 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // Offer one request, wait for acceptance and queue its expected events
    task automatic send_request(input logic [2:0] op, input logic [3:0] idx,
                                input logic [2:0] sel, input logic typed = 1'b0,
                                input logic [7:0] typed_val = 8'd0);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        request_index  <= idx;
        counter_select <= sel;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_request(op, idx, sel);
        if (typed)
            pending_events.push_back('{EV_READ, 4'd0, typed_val, 1'b1});
        else
            foreach (step_events[j])
                pending_events.push_back(step_events[j]);
    endtask

    // Drop valid and wait until every expected event has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register once the block is idle
    task automatic write_register(input logic reg_sel, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= data;
        @(posedge clk);
        if (reg_sel == CFG_GATE_ENABLES)
            gate_cfg = data[GATE_W-1:0];
        else
            wdog_trig = data;
    endtask

    // Mixed requests; flag bursts followed by a tick make up a good share
    task automatic run_mixed(input int n_items);
        int done;
        int r;
        int k;
        done = 0;
        while (done < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 38)
            begin
                send_request(OP_TICK, 4'($urandom), 3'($urandom));
                done++;
            end
            else if (r < 56)
            begin
                send_request(OP_SET_FLAG, 4'($urandom), 3'($urandom));
                done++;
            end
            else if (r < 68)
            begin
                send_request(OP_READ, 4'($urandom), 3'($urandom));
                done++;
            end
            else if (r < 78)
            begin
                send_request(OP_RESET, 4'($urandom), 3'($urandom));
                done++;
            end
            else if (r < 84)
            begin
                send_request(OP_CLEAR_ALL, 4'($urandom), 3'($urandom));
                done++;
            end
            else if (r < 94)
            begin
                // Raise a handful of flags, then tick to service them
                k = $urandom_range(2, 6);
                repeat (k) send_request(OP_SET_FLAG, 4'($urandom), 3'($urandom));
                send_request(OP_TICK, 4'($urandom), 3'($urandom));
                done += k + 1;
            end
            else
            begin
                // Ignored opcode: no effect, not counted
                send_request(3'($urandom_range(OP_SPARE5, OP_SPARE7)), 4'($urandom),
                             3'($urandom));
            end
        end
    endtask

    // Check each delivered event against the oldest expectation
    always @(posedge clk)
    begin : check_events
        sched_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event_kind: expected no event, got %0d", event_kind);
                fail_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                    fail_count++;
                end
                if (request_number !== want.number)
                begin
                    $error("request_number: expected %0d, got %0d", want.number,
                           request_number);
                    fail_count++;
                end
                if (read_value !== want.value)
                begin
                    $error("read_value: expected %0d, got %0d", want.value, read_value);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Drive out_ready: random stall bursts, one long hold on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        step_row_t row;
        int        tail_items;
        int        r;
        bit        wrapped;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_TICK;
        request_index  = '0;
        counter_select = SEL_CPU;
        cfg_we         = 1'b0;
        cfg_index      = CFG_GATE_ENABLES;
        cfg_data       = '0;
        fail_count     = 0;
        quiet          = 1'b0;
        long_hold_req  = 1'b0;
        sched_phase    = 0;
        cpu_ms         = '0;
        intset_ms      = '0;
        inthold_ms     = '0;
        derate_s       = '0;
        battery_s      = '0;
        wdog_ms        = '0;
        flag_bits      = '0;
        gate_cfg       = '0;
        wdog_trig      = WATCHDOG_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int s = 0; s < DIRECTED_ROWS; s++)
        begin
            row = DIRECTED_STEPS[s];
            if (row.kind == ROW_WRITE)
                write_register(row.reg_sel, row.data);
            else
                send_request(row.op, row.idx, row.sel, row.typed, row.typed_val);
        end

        // Random gates, watchdog trigger never reached
        write_register(CFG_GATE_ENABLES, 32'($urandom_range(0, 31)));
        write_register(CFG_WATCHDOG_TRIGGER, 32'd0);
        run_mixed(26);

        // All gates on, near trigger; hold the receiver off so the input stalls
        write_register(CFG_GATE_ENABLES, 32'd31);
        write_register(CFG_WATCHDOG_TRIGGER, wdog_ms + 32'($urandom_range(2, 15)));
        long_hold_req = 1'b1;
        run_mixed(26);

        // All gates off; pause the sender until everything has drained
        write_register(CFG_GATE_ENABLES, 32'd0);
        write_register(CFG_WATCHDOG_TRIGGER, 32'hFFFF_FFFF);
        run_mixed(13);
        wait_drained();
        run_mixed(13);

        write_register(CFG_GATE_ENABLES, 32'($urandom_range(0, 31)));
        write_register(CFG_WATCHDOG_TRIGGER, wdog_ms + 32'($urandom_range(1, 10)));
        run_mixed(26);

        write_register(CFG_GATE_ENABLES, 32'($urandom_range(0, 31)) | 32'd1);
        write_register(CFG_WATCHDOG_TRIGGER, $urandom);
        run_mixed(26);

        // Tick past every second boundary and the phase wrap with no idling;
        // at the wrap all flags, periodic events, watchdog and seconds coincide
        write_register(CFG_GATE_ENABLES, 32'd31);
        write_register(CFG_WATCHDOG_TRIGGER, wdog_ms + 32'(PHASE_WRAP - sched_phase));
        quiet      = 1'b1;
        wrapped    = 1'b0;
        tail_items = 0;
        while (tail_items < 8)
        begin
            if (!wrapped && sched_phase == PHASE_WRAP - 1)
            begin
                for (int f = 0; f < MAX_FLAGS; f++)
                    send_request(OP_SET_FLAG, 4'(f), 3'($urandom));
                send_request(OP_TICK, 4'($urandom), 3'($urandom));
                wrapped = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 92)
                    send_request(OP_TICK, 4'($urandom), 3'($urandom));
                else if (r < 96)
                    send_request(OP_SET_FLAG, 4'($urandom), 3'($urandom));
                else
                    send_request(OP_READ, 4'($urandom), 3'($urandom));
                if (wrapped)
                    tail_items++;
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/tsgc_pkg.sv
rtl/tsgc_front.sv
rtl/tsgc_queue.sv
rtl/tsgc_back.sv
rtl/tick_scheduler_with_gated_counters.sv
test/tick_scheduler_with_gated_counters_tb.sv
